[hdl/kwlc_pkg.sv]
// ---------------------------------------------------------------------------
// Keyword line counter package
// Shared types, constants and the pattern matcher used by the line tracker.
// ---------------------------------------------------------------------------
package kwlc_pkg;

	localparam int BYTE_W       = 8;
	localparam int HIST_DEPTH   = 7;
	localparam int NUM_PATTERNS = 18;
	localparam int PAT_W        = BYTE_W * (HIST_DEPTH + 1);
	localparam int COUNT_OUT_W  = 24;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

	// Patterns are right-aligned: the last character sits in the low byte.
	localparam logic [PAT_W-1:0] PAT_TEXT [NUM_PATTERNS] = '{
		PAT_W'("/"), PAT_W'("*"), PAT_W'(";"), PAT_W'("if"), PAT_W'("else"),
		PAT_W'("try"), PAT_W'("catch"), PAT_W'("switch"), PAT_W'("for"),
		PAT_W'("while"), PAT_W'("do"), PAT_W'("return"), PAT_W'("break"),
		PAT_W'("continue"), PAT_W'("exit"), PAT_W'("throw"), PAT_W'("public"),
		PAT_W'("private")
	};

	localparam logic [3:0] PAT_LEN [NUM_PATTERNS] = '{
		4'd1, 4'd1, 4'd1, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd3,
		4'd5, 4'd2, 4'd6, 4'd5, 4'd8, 4'd4, 4'd5, 4'd6, 4'd7
	};

	// Previous bytes of the line, element 0 is the most recent one.
	typedef logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_t;

	typedef struct packed {
		logic                   emit;
		logic                   line_matched;
		logic [COUNT_OUT_W-1:0] running_count;
		logic                   final_total;
	} res_t;

	// True if any pattern ends at the current byte.
	function automatic logic match_here(input logic [BYTE_W-1:0] cur, input hist_t hist);
		logic [HIST_DEPTH:0][BYTE_W-1:0] win;
		logic hit;
		logic ok;
		win = {hist, cur};
		hit = 1'b0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			ok = 1'b1;
			for (int k = 0; k <= HIST_DEPTH; k++) begin
				if (k < int'(PAT_LEN[p]) && win[k] != PAT_TEXT[p][BYTE_W*k +: BYTE_W]) begin
					ok = 1'b0;
				end
			end
			hit = hit | ok;
		end
		return hit;
	endfunction

endpackage

[hdl/kwlc_text_if.sv]
// ---------------------------------------------------------------------------
// Text channel
// Carries one character of source text per item, with an end-of-text mark.
// ---------------------------------------------------------------------------
interface kwlc_text_if;
	logic                         valid;
	logic                         ready;
	logic [kwlc_pkg::BYTE_W-1:0] text_byte;
	logic                         end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[hdl/kwlc_result_if.sv]
// ---------------------------------------------------------------------------
// Result channel
// Carries the match flag and running count at the end of each counted line.
// ---------------------------------------------------------------------------
interface kwlc_result_if;
	logic                              valid;
	logic                              ready;
	logic                              line_matched;
	logic [kwlc_pkg::COUNT_OUT_W-1:0] running_count;
	logic                              final_total;

	modport source (output valid, output line_matched, output running_count,
		output final_total, input ready);
	modport sink (input valid, input line_matched, input running_count,
		input final_total, output ready);
endinterface

[hdl/keyword_line_counter_unit.sv]
// ---------------------------------------------------------------------------
// Keyword line counter
// Counts lines of source text that contain a keyword or a marker character.
// ---------------------------------------------------------------------------
// The text channel takes one character per item; end_of_text marks the last
// one. Each non-empty line yields one item on the result channel when its
// newline arrives, carrying whether the line held a pattern and the count
// of such lines so far. The last character of a text always yields a
// result with final_total set, after which the count restarts at zero.
// Empty lines yield nothing unless they end the text.
// An accepted character is held in an input register; its result is formed
// combinationally from that register and lands in the result register when
// the character advances, from where the receiver can take it. One
// character is taken every cycle unless a result waits on a stalled receiver;
// the pattern compare over the seven-byte line history is combinational.
// When the receiver stalls, the result register holds its item; characters
// that yield no result still flow, and the input side stops only once a
// second result would be needed. Reset clears the count, the history and
// the valid flags of both registers.
// ---------------------------------------------------------------------------
module keyword_line_counter_unit #(
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kwlc_text_if.sink             text,
	kwlc_result_if.source         result
);

	logic                          valid_s1;
	logic [kwlc_pkg::BYTE_W-1:0]  byte_s1;
	logic                          last_s1;

	logic                              res_valid_q;
	logic                              res_matched_q;
	logic [kwlc_pkg::COUNT_OUT_W-1:0] res_count_q;
	logic                              res_final_q;

	kwlc_pkg::res_t res;
	logic           advance;

	assign advance    = valid_s1 & (~res.emit | ~res_valid_q | result.ready);
	assign text.ready = ~valid_s1 | advance;

	kwlc_line #(
		.COUNT_BITS(COUNT_BITS)
	) u_line (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			res_matched_q <= res.line_matched;
			res_count_q   <= res.running_count;
			res_final_q   <= res.final_total;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.line_matched  = res_matched_q;
	assign result.running_count = res_count_q;
	assign result.final_total   = res_final_q;

endmodule

[hdl/kwlc_line.sv]
// ---------------------------------------------------------------------------
// Keyword line counter line tracker
// Holds the per-line history and the line count, and forms the result of
// the item presented to it in the same cycle.
// ---------------------------------------------------------------------------
module kwlc_line #(
	parameter int COUNT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [kwlc_pkg::BYTE_W-1:0]  text_byte,
	input  logic                          end_of_text,
	output kwlc_pkg::res_t                res
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	kwlc_pkg::hist_t         hist_q;
	logic                    has_text_q;
	logic                    hit_q;
	logic [COUNT_BITS-1:0]   count_q;

	logic                    is_nl;
	logic                    hit_now;
	logic                    hit_nx;
	logic                    close;
	logic                    closed_hit;
	logic [COUNT_BITS-1:0]   count_nx;

	assign is_nl      = (text_byte == kwlc_pkg::NEWLINE_BYTE);
	assign hit_now    = kwlc_pkg::match_here(text_byte, hist_q);
	assign hit_nx     = hit_q | (~is_nl & hit_now);
	// A newline closes only a non-empty line; any other last byte closes its line.
	assign close      = is_nl ? has_text_q : end_of_text;
	assign closed_hit = close & hit_nx;
	assign count_nx   = (closed_hit && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

	assign res.emit         = close | end_of_text;
	assign res.line_matched = closed_hit;
	assign res.final_total  = end_of_text;

	generate
		if (COUNT_BITS >= kwlc_pkg::COUNT_OUT_W) begin : g_trunc
			assign res.running_count = count_nx[kwlc_pkg::COUNT_OUT_W-1:0];
		end else begin : g_ext
			assign res.running_count = {{(kwlc_pkg::COUNT_OUT_W-COUNT_BITS){1'b0}}, count_nx};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q     <= '0;
			has_text_q <= 1'b0;
			hit_q      <= 1'b0;
			count_q    <= '0;
		end else if (step) begin
			if (end_of_text) begin
				hist_q     <= '0;
				has_text_q <= 1'b0;
				hit_q      <= 1'b0;
				count_q    <= '0;
			end else if (is_nl) begin
				hist_q     <= '0;
				has_text_q <= 1'b0;
				hit_q      <= 1'b0;
				count_q    <= count_nx;
			end else begin
				hist_q     <= {hist_q[kwlc_pkg::HIST_DEPTH-2:0], text_byte};
				has_text_q <= 1'b1;
				hit_q      <= hit_nx;
			end
		end
	end

endmodule

[hdl/kwlc_check.sv]
// ---------------------------------------------------------------------------
// Keyword line counter checker
// Watches the ports of the counter and checks result ordering and counts.
// ---------------------------------------------------------------------------
module kwlc_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              in_last,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              out_matched,
	input  logic [kwlc_pkg::COUNT_OUT_W-1:0] out_count,
	input  logic                              out_final
);

	logic                              in_acc;
	logic                              out_acc;
	logic                              after_final_q;
	logic [kwlc_pkg::COUNT_OUT_W-1:0] last_count_q;
	logic [2:0]                        finals_q;
	logic                              fin_in;
	logic                              fin_out;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;
	assign fin_in  = in_acc & in_last;
	assign fin_out = out_acc & out_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_final_q <= 1'b1;
			last_count_q  <= '0;
			finals_q      <= '0;
		end else begin
			if (out_acc) begin
				after_final_q <= out_final;
				last_count_q  <= out_count;
			end
			if (fin_in && !fin_out) begin
				finals_q <= finals_q + 3'd1;
			end else if (!fin_in && fin_out) begin
				finals_q <= finals_q - 3'd1;
			end
		end
	end

	// A stalled result keeps its item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_count)
			&& $stable(out_matched) && $stable(out_final))
		else $error("result changed while stalled");

	// A line without a pattern leaves the count where it was.
	a_count_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !out_matched |->
			out_count == (after_final_q ? '0 : last_count_q))
		else $error("count moved on an unmatched line");

	// A final result needs an accepted end-of-text character behind it.
	a_final_owed: assert property (@(posedge clk) disable iff (!arst_n)
		fin_out |-> finals_q != 3'd0)
		else $error("final result without end of text");

	// At most the input register and the result register hold texts' ends.
	a_final_depth: assert property (@(posedge clk) disable iff (!arst_n)
		finals_q <= 3'd2)
		else $error("too many texts outstanding");

endmodule

bind keyword_line_counter_unit kwlc_check u_kwlc_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (text.valid),
	.in_ready    (text.ready),
	.in_last     (text.end_of_text),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_matched (result.line_matched),
	.out_count   (result.running_count),
	.out_final   (result.final_total)
);
